@@ rtl/pcc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcc_pkg
// Widths, constants, the per-beat pipeline record and the pin popcount
// shared by the pin change capture unit.
// ----------------------------------------------------------------------------
package pcc_pkg;

    localparam int LEVEL_W = 8;
    localparam int IDX_W   = 6;
    localparam int TIME_W  = 64;
    localparam int DUR_W   = 32;
    localparam int NUM_W   = 16;
    localparam int CNT_W   = 32;
    localparam int REL_W   = 32;
    localparam int ACT_W   = 4;
    localparam int TOP_PIN = 7;

    localparam int PROD_W = IDX_W + DUR_W;
    localparam int PART_W = PROD_W / 2;

    localparam int SAMPLES_PER_PACKET_DEF = 64;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic               change;
        logic [LEVEL_W-1:0] levels;
        logic [LEVEL_W-1:0] mask;
        logic               lost;
        logic [CNT_W-1:0]   events;
        logic [CNT_W-1:0]   samples;
        logic [ACT_W-1:0]   active;
        logic               done;
        logic               first;
        logic [REL_W-1:0]   start_lo;
    } t_info;

    function automatic logic [ACT_W-1:0] ones_in(input logic [LEVEL_W-1:0] v);
        logic [ACT_W-1:0] n;
        n = '0;
        for (int k = 0; k <= TOP_PIN; k++) begin
            n = n + ACT_W'(v[k]);
        end
        return n;
    endfunction

endpackage

@@ rtl/pin_change_capture_unit.sv @@
// ----------------------------------------------------------------------------
// pin_change_capture_unit
// Transition detector for an eight-pin capture stream with interpolated
// change times, lost-packet check and saturating statistics.
// Throughput: one beat per cycle while not stalled; the divide by the packet
// sample spacing is a reciprocal multiply split into partial products over
// two stages, and each beat passes stages s1 to s4 and the output register.
// Reset clears the pipeline valid flags, the previous levels, the packet
// number check, the first change time flag, the pin mask and both counters.
// ----------------------------------------------------------------------------
module pin_change_capture_unit #(
    parameter int SAMPLES_PER_PACKET = pcc_pkg::SAMPLES_PER_PACKET_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [pcc_pkg::LEVEL_W-1:0]  i_pin_sample,
    input  logic [pcc_pkg::IDX_W-1:0]    i_sample_index,
    input  logic [pcc_pkg::TIME_W-1:0]   i_packet_start_time,
    input  logic [pcc_pkg::DUR_W-1:0]    i_packet_duration,
    input  logic [pcc_pkg::NUM_W-1:0]    i_packet_number,
    input  logic                         i_final_packet,

    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_change_valid,
    output logic signed [pcc_pkg::REL_W-1:0] o_relative_time,
    output logic [pcc_pkg::LEVEL_W-1:0]  o_new_levels,
    output logic [pcc_pkg::LEVEL_W-1:0]  o_changed_mask,
    output logic                         o_packet_lost,
    output logic [pcc_pkg::CNT_W-1:0]    o_event_total,
    output logic [pcc_pkg::CNT_W-1:0]    o_sample_total,
    output logic [pcc_pkg::ACT_W-1:0]    o_active_pin_count,
    output logic                         o_capture_done
);

    localparam int Div     = SAMPLES_PER_PACKET - 1;
    localparam int DivLog  = $clog2(Div);
    localparam int Shift   = pcc_pkg::PROD_W + DivLog;
    localparam int RecipW  = pcc_pkg::PROD_W + 1;
    localparam int HiW     = RecipW - pcc_pkg::PART_W;
    localparam int PHiW    = pcc_pkg::PROD_W - pcc_pkg::PART_W;
    localparam int FullW   = pcc_pkg::PROD_W + RecipW;
    localparam int LlW     = 2 * pcc_pkg::PART_W;
    localparam int LhW     = pcc_pkg::PART_W + HiW;
    localparam int HlW     = PHiW + pcc_pkg::PART_W;
    localparam int HhW     = PHiW + HiW;
    localparam logic [63:0] RecipFull =
        ((64'd1 << Shift) + 64'(Div) - 64'd1) / 64'(Div);
    localparam logic [RecipW-1:0] Recip   = RecipFull[RecipW-1:0];
    localparam logic [pcc_pkg::PART_W-1:0] RecipLo = Recip[pcc_pkg::PART_W-1:0];
    localparam logic [HiW-1:0] RecipHi = Recip[RecipW-1:pcc_pkg::PART_W];

    // Architectural state.
    logic [pcc_pkg::LEVEL_W-1:0] r_prev,    n_prev;
    logic [pcc_pkg::NUM_W-1:0]   r_exp,     n_exp;
    logic                        r_exp_valid, n_exp_valid;
    logic                        r_first_set, n_first_set;
    logic [pcc_pkg::REL_W-1:0]   r_first_time;
    logic [pcc_pkg::LEVEL_W-1:0] r_toggled, n_toggled;
    logic [pcc_pkg::CNT_W-1:0]   r_events,  n_events;
    logic [pcc_pkg::CNT_W-1:0]   r_samples, n_samples;

    // Pipeline.
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;
    logic free1, free2, free3, free4, free5, accept;

    pcc_pkg::t_info r_s1_info, r_s2_info, r_s3_info, r_s4_info, n_info;
    logic [pcc_pkg::PROD_W-1:0]      r_s1_prod;
    logic [2*pcc_pkg::PART_W-1:0]    r_s2_ll;
    logic [pcc_pkg::PART_W+HiW-1:0]  r_s2_lh;
    logic [PHiW+pcc_pkg::PART_W-1:0] r_s2_hl;
    logic [PHiW+HiW-1:0]             r_s2_hh;
    logic [pcc_pkg::REL_W-1:0]       r_s3_quo;
    logic [pcc_pkg::REL_W-1:0]       r_s4_tlo;

    logic                        r_out_change;
    logic [pcc_pkg::REL_W-1:0]   r_out_rel;
    logic [pcc_pkg::LEVEL_W-1:0] r_out_levels;
    logic [pcc_pkg::LEVEL_W-1:0] r_out_mask;
    logic                        r_out_lost;
    logic [pcc_pkg::CNT_W-1:0]   r_out_events;
    logic [pcc_pkg::CNT_W-1:0]   r_out_samples;
    logic [pcc_pkg::ACT_W-1:0]   r_out_active;
    logic                        r_out_done;

    logic [pcc_pkg::LEVEL_W-1:0] diff;
    logic [pcc_pkg::CNT_W:0]     event_sum;
    logic [pcc_pkg::PART_W-1:0]  p_lo;
    logic [PHiW-1:0]             p_hi;
    logic [FullW-1:0]            full_prod;
    logic [FullW-1:0]            shifted;

    assign free5  = !r_s5_v || !i_stall;
    assign free4  = !r_s4_v || free5;
    assign free3  = !r_s3_v || free4;
    assign free2  = !r_s2_v || free3;
    assign free1  = !r_s1_v || free2;
    assign accept = i_valid && free1;
    assign o_stall = !free1;

    always_comb begin
        diff        = i_pin_sample ^ r_prev;
        n_prev      = r_prev;
        n_exp       = r_exp;
        n_exp_valid = r_exp_valid;
        n_first_set = r_first_set;
        n_toggled   = r_toggled;
        n_events    = r_events;
        n_samples   = (r_samples == pcc_pkg::COUNT_MAX) ? r_samples
                                                        : r_samples + pcc_pkg::CNT_W'(1);
        event_sum   = {1'b0, r_events} + (pcc_pkg::CNT_W + 1)'(pcc_pkg::ones_in(diff));

        n_info          = '0;
        n_info.samples  = n_samples;
        n_info.start_lo = i_packet_start_time[pcc_pkg::REL_W-1:0];
        n_info.done     = i_final_packet && (32'(i_sample_index) == 32'(Div));

        if (i_sample_index == '0) begin
            n_info.lost = r_exp_valid && (i_packet_number != r_exp);
            n_exp       = i_packet_number + pcc_pkg::NUM_W'(1);
            n_exp_valid = 1'b1;
        end

        if (diff != '0) begin
            n_info.change = 1'b1;
            n_info.levels = i_pin_sample;
            n_info.mask   = diff;
            n_info.first  = !r_first_set;
            n_first_set   = 1'b1;
            n_toggled     = r_toggled | diff;
            n_events      = event_sum[pcc_pkg::CNT_W] ? pcc_pkg::COUNT_MAX
                                                      : event_sum[pcc_pkg::CNT_W-1:0];
            n_prev        = i_pin_sample;
        end

        n_info.events = n_events;
        n_info.active = pcc_pkg::ones_in(n_toggled);
    end

    assign p_lo = r_s1_prod[pcc_pkg::PART_W-1:0];
    assign p_hi = r_s1_prod[pcc_pkg::PROD_W-1:pcc_pkg::PART_W];

    assign full_prod = (FullW'(r_s2_hh) << (2 * pcc_pkg::PART_W))
                     + ((FullW'(r_s2_lh) + FullW'(r_s2_hl)) << pcc_pkg::PART_W)
                     + FullW'(r_s2_ll);
    assign shifted   = full_prod >> Shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_exp       <= '0;
            r_exp_valid <= 1'b0;
            r_first_set <= 1'b0;
            r_toggled   <= '0;
            r_events    <= '0;
            r_samples   <= '0;
            r_s1_v      <= 1'b0;
            r_s2_v      <= 1'b0;
            r_s3_v      <= 1'b0;
            r_s4_v      <= 1'b0;
            r_s5_v      <= 1'b0;
        end else begin
            if (accept) begin
                r_prev      <= n_prev;
                r_exp       <= n_exp;
                r_exp_valid <= n_exp_valid;
                r_first_set <= n_first_set;
                r_toggled   <= n_toggled;
                r_events    <= n_events;
                r_samples   <= n_samples;
            end
            if (free1) r_s1_v <= i_valid;
            if (free2) r_s2_v <= r_s1_v;
            if (free3) r_s3_v <= r_s2_v;
            if (free4) r_s4_v <= r_s3_v;
            if (free5) r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free1) begin
            r_s1_info <= n_info;
            r_s1_prod <= pcc_pkg::PROD_W'(i_sample_index) * pcc_pkg::PROD_W'(i_packet_duration);
        end
        if (free2) begin
            r_s2_info <= r_s1_info;
            r_s2_ll   <= LlW'(p_lo) * LlW'(RecipLo);
            r_s2_lh   <= LhW'(p_lo) * LhW'(RecipHi);
            r_s2_hl   <= HlW'(p_hi) * HlW'(RecipLo);
            r_s2_hh   <= HhW'(p_hi) * HhW'(RecipHi);
        end
        if (free3) begin
            r_s3_info <= r_s2_info;
            r_s3_quo  <= shifted[pcc_pkg::REL_W-1:0];
        end
        if (free4) begin
            r_s4_info <= r_s3_info;
            r_s4_tlo  <= r_s3_info.start_lo + r_s3_quo;
        end
        if (free5) begin
            r_out_change  <= r_s4_info.change;
            r_out_levels  <= r_s4_info.levels;
            r_out_mask    <= r_s4_info.mask;
            r_out_lost    <= r_s4_info.lost;
            r_out_events  <= r_s4_info.events;
            r_out_samples <= r_s4_info.samples;
            r_out_active  <= r_s4_info.active;
            r_out_done    <= r_s4_info.done;
            if (r_s4_info.change && !r_s4_info.first) begin
                r_out_rel <= r_s4_tlo - r_first_time;
            end else begin
                r_out_rel <= '0;
            end
        end
        if (free5 && r_s4_v && r_s4_info.first) begin
            r_first_time <= r_s4_tlo;
        end
    end

    assign o_valid            = r_s5_v;
    assign o_change_valid     = r_out_change;
    assign o_relative_time    = r_out_rel;
    assign o_new_levels       = r_out_levels;
    assign o_changed_mask     = r_out_mask;
    assign o_packet_lost      = r_out_lost;
    assign o_event_total      = r_out_events;
    assign o_sample_total     = r_out_samples;
    assign o_active_pin_count = r_out_active;
    assign o_capture_done     = r_out_done;

    a_no_change_is_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_change_valid) |-> (o_relative_time == '0 && o_changed_mask == '0
                                          && o_new_levels == '0))
        else $error("quiet beat carries change data");

    a_first_after_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_v && r_s4_info.first) |-> r_first_set)
        else $error("first change in flight without first change flag");

    a_samples_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_samples >= $past(r_samples)))
        else $error("sample counter went backwards");

endmodule
